// File: sv/windowed_pulse_rate_meter_core_defines.svh
// assertion macros for the windowed pulse rate meter
// expects clk and rst_n in the scope of use
`ifndef WINDOWED_PULSE_RATE_METER_CORE_DEFINES_SVH
`define WINDOWED_PULSE_RATE_METER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WPRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPRM_ASSERT(lbl, prop, msg)
`define WPRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: sv/wprm_pkg.sv
// shared constants and types for the windowed pulse rate meter
// no dependencies
`timescale 1ns / 1ps
package wprm_pkg;

  localparam int TALLY_W = 32;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int SCALE_W = 24;
  localparam int PPU_W   = 16;
  localparam int RATE_W  = 16;
  localparam int NUM_W   = TALLY_W + SCALE_W;
  localparam int DEN_W   = TIME_W + PPU_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPU    = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RST = 16'd500;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd100000;
  localparam logic [PPU_W-1:0]   PPU_RST    = 16'd75;
  localparam logic [RATE_W-1:0]  RATE_MAX   = 16'hffff;

  typedef struct packed {
    logic             qbit;
    logic [DEN_W-1:0] rem;
  } wprm_step_t;

endpackage

// File: sv/wprm_alu.sv
// shared arithmetic unit: one 32x24 multiplier, saturation compare, one divide step
// depends on wprm_pkg
`timescale 1ns / 1ps
module wprm_alu (
  input  logic                           sel_den,
  input  logic [wprm_pkg::TALLY_W-1:0]   tally,
  input  logic [wprm_pkg::SCALE_W-1:0]   scale,
  input  logic [wprm_pkg::TIME_W-1:0]    elapsed,
  input  logic [wprm_pkg::PPU_W-1:0]     ppu,
  input  logic [wprm_pkg::NUM_W-1:0]     num,
  input  logic [wprm_pkg::DEN_W-1:0]     den,
  input  logic [wprm_pkg::DEN_W-1:0]     rem,
  output logic [wprm_pkg::NUM_W-1:0]     prod,
  output logic                           sat,
  output wprm_pkg::wprm_step_t           step
);

  localparam int HI_W = wprm_pkg::NUM_W - wprm_pkg::RATE_W;

  logic [wprm_pkg::TALLY_W-1:0] op_a;
  logic [wprm_pkg::SCALE_W-1:0] op_b;
  logic [wprm_pkg::DEN_W:0]     trial;
  logic [wprm_pkg::DEN_W:0]     diff;
  logic                         ge;

  always_comb begin
    if (sel_den) begin
      op_a = elapsed;
      op_b = {{(wprm_pkg::SCALE_W - wprm_pkg::PPU_W){1'b0}}, ppu};
    end else begin
      op_a = tally;
      op_b = scale;
    end
  end

  assign prod = wprm_pkg::NUM_W'(op_a) * wprm_pkg::NUM_W'(op_b);

  // quotient overflows 16 bits (or divisor is zero) when num >> 16 >= den
  assign sat = {{(wprm_pkg::DEN_W - HI_W){1'b0}}, num[wprm_pkg::NUM_W-1:wprm_pkg::RATE_W]} >= den;

  assign trial = {rem, num[wprm_pkg::RATE_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    step.qbit = ge;
    step.rem  = ge ? diff[wprm_pkg::DEN_W-1:0] : trial[wprm_pkg::DEN_W-1:0];
  end

endmodule

// File: sv/windowed_pulse_rate_meter_core.sv
// windowed pulse rate meter: pulse tally, read sequencer and result register
// depends on wprm_pkg, wprm_alu and windowed_pulse_rate_meter_core_defines.svh
// pulse edge: taken with no result; next item the cycle after
// read below window: finish step, then held rate registered once output is free
// read with new rate: multiply twice, check, 16 divide steps; saturated: check to finish
// one request in work at a time; synchronous active-low reset restores register defaults
`timescale 1ns / 1ps
`include "windowed_pulse_rate_meter_core_defines.svh"
module windowed_pulse_rate_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [wprm_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wprm_pkg::RATE_W-1:0]       out_rate_x10,
  input  logic                              cfg_we,
  input  logic [wprm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wprm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULN = 3'd1;
  localparam logic [2:0] ST_MULD = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  logic [wprm_pkg::WIN_W-1:0]   window_r, window_nxt;
  logic [wprm_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [wprm_pkg::PPU_W-1:0]   ppu_r, ppu_nxt;

  logic [wprm_pkg::TALLY_W-1:0] pulse_tally_r, pulse_tally_nxt;
  logic [wprm_pkg::TIME_W-1:0]  last_time_r, last_time_nxt;
  logic [wprm_pkg::RATE_W-1:0]  held_rate_r, held_rate_nxt;

  logic [wprm_pkg::TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [wprm_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [wprm_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [wprm_pkg::DEN_W-1:0]   rem_r, rem_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [wprm_pkg::RATE_W-1:0]  out_rate_r, out_rate_nxt;

  logic [wprm_pkg::TIME_W-1:0]  elapsed_now;
  logic                         in_take;
  logic                         out_free;
  logic [wprm_pkg::NUM_W-1:0]   prod;
  logic                         sat;
  wprm_pkg::wprm_step_t         step;

  wprm_alu u_alu (
    .sel_den (state_r == ST_MULD),
    .tally   (pulse_tally_r),
    .scale   (scale_r),
    .elapsed (elapsed_r),
    .ppu     (ppu_r),
    .num     (num_r),
    .den     (den_r),
    .rem     (rem_r),
    .prod    (prod),
    .sat     (sat),
    .step    (step)
  );

  assign in_stall     = (state_r != ST_IDLE);
  assign in_take      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign elapsed_now  = in_now_ms - last_time_r;
  assign out_valid    = out_valid_r;
  assign out_rate_x10 = out_rate_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    window_nxt      = window_r;
    scale_nxt       = scale_r;
    ppu_nxt         = ppu_r;
    pulse_tally_nxt = pulse_tally_r;
    last_time_nxt   = last_time_r;
    held_rate_nxt   = held_rate_r;
    elapsed_nxt     = elapsed_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_rate_nxt    = out_rate_r;

    if (cfg_we) begin
      case (cfg_index)
        wprm_pkg::CFG_WINDOW: window_nxt = cfg_wdata[wprm_pkg::WIN_W-1:0];
        wprm_pkg::CFG_SCALE:  scale_nxt  = cfg_wdata[wprm_pkg::SCALE_W-1:0];
        wprm_pkg::CFG_PPU:    ppu_nxt    = cfg_wdata[wprm_pkg::PPU_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (!in_opcode) begin
            pulse_tally_nxt = pulse_tally_r + 1'b1;
          end else if (elapsed_now >= {{(wprm_pkg::TIME_W - wprm_pkg::WIN_W){1'b0}}, window_r}) begin
            elapsed_nxt   = elapsed_now;
            last_time_nxt = in_now_ms;
            state_nxt     = ST_MULN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MULN: begin
        num_nxt         = prod;
        pulse_tally_nxt = '0;
        state_nxt       = ST_MULD;
      end
      ST_MULD: begin
        den_nxt   = prod[wprm_pkg::DEN_W-1:0];
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sat) begin
          held_rate_nxt = wprm_pkg::RATE_MAX;
          state_nxt     = ST_FIN;
        end else begin
          rem_nxt   = {{(wprm_pkg::DEN_W - (wprm_pkg::NUM_W - wprm_pkg::RATE_W)){1'b0}},
                       num_r[wprm_pkg::NUM_W-1:wprm_pkg::RATE_W]};
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = step.rem;
        num_nxt = {num_r[wprm_pkg::NUM_W-2:0], step.qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          held_rate_nxt = {num_r[wprm_pkg::RATE_W-2:0], step.qbit};
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = held_rate_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      window_r      <= wprm_pkg::WINDOW_RST;
      scale_r       <= wprm_pkg::SCALE_RST;
      ppu_r         <= wprm_pkg::PPU_RST;
      pulse_tally_r <= '0;
      last_time_r   <= '0;
      held_rate_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      window_r      <= window_nxt;
      scale_r       <= scale_nxt;
      ppu_r         <= ppu_nxt;
      pulse_tally_r <= pulse_tally_nxt;
      last_time_r   <= last_time_nxt;
      held_rate_r   <= held_rate_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r  <= elapsed_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    out_rate_r <= out_rate_nxt;
  end

  // partial remainder stays below the divisor throughout the divide
  `WPRM_ASSERT(a_rem_below_den, (state_r == ST_DIV) |-> (rem_r < den_r), "remainder not below divisor")
  // a pulse edge bumps the tally by one
  `WPRM_ASSERT(a_pulse_count, (in_take && !in_opcode) |=> (pulse_tally_r == $past(pulse_tally_r) + 1'b1), "pulse tally did not advance")
  // a result appears only out of the finish step
  `WPRM_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> ($past(state_r) == ST_FIN), "result without finish step")
  // the sixteenth divide step leads to the finish step
  `WPRM_ASSERT(a_div_to_fin, (state_r == ST_DIV && cnt_r == 4'd15) |=> (state_r == ST_FIN), "divide did not finish")

endmodule

// File: tb/wprm_tb_pkg.sv
// request opcodes and spare register index shared by the meter testbench files
// depends on wprm_pkg
`timescale 1ns / 1ps
package wprm_tb_pkg;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_READ  = 1'b1
  } meter_op_e;

  // index beyond the last register, writes to it are dropped
  localparam logic [wprm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

endpackage

// File: tb/wprm_rate_checker.sv
// rate checker for the windowed pulse rate meter: mirrors tally, window and
// held rate from the observed channels and compares every accepted rate
// depends on wprm_pkg and wprm_tb_pkg
`timescale 1ns / 1ps
module wprm_rate_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [wprm_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [wprm_pkg::RATE_W-1:0]       out_rate_x10,
  input  logic                              cfg_we,
  input  logic [wprm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wprm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                owed_count
);

  logic [wprm_pkg::WIN_W-1:0]   window_reg;
  logic [wprm_pkg::SCALE_W-1:0] scale_reg;
  logic [wprm_pkg::PPU_W-1:0]   ppu_reg;
  logic [wprm_pkg::TALLY_W-1:0] tally;
  logic [wprm_pkg::TIME_W-1:0]  last_calc_ms;
  logic [wprm_pkg::RATE_W-1:0]  held_rate;
  logic [wprm_pkg::RATE_W-1:0]  owed_rates[$];
  int                           fails = 0;

  function automatic logic [wprm_pkg::RATE_W-1:0] rate_from_tally(
    logic [wprm_pkg::TALLY_W-1:0] pulses,
    logic [wprm_pkg::TIME_W-1:0]  elapsed);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = 64'(pulses) * 64'(scale_reg);
    den = 64'(elapsed) * 64'(ppu_reg);
    if (den == 64'd0) return wprm_pkg::RATE_MAX;
    quo = num / den;
    if (quo > 64'(wprm_pkg::RATE_MAX)) return wprm_pkg::RATE_MAX;
    return quo[wprm_pkg::RATE_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic [wprm_pkg::TIME_W-1:0] elapsed;
    logic [wprm_pkg::RATE_W-1:0] want;
    if (!rst_n) begin
      window_reg   = wprm_pkg::WINDOW_RST;
      scale_reg    = wprm_pkg::SCALE_RST;
      ppu_reg      = wprm_pkg::PPU_RST;
      tally        = '0;
      last_calc_ms = '0;
      held_rate    = '0;
      owed_rates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wprm_pkg::CFG_WINDOW: window_reg = cfg_wdata[wprm_pkg::WIN_W-1:0];
          wprm_pkg::CFG_SCALE:  scale_reg  = cfg_wdata[wprm_pkg::SCALE_W-1:0];
          wprm_pkg::CFG_PPU:    ppu_reg    = cfg_wdata[wprm_pkg::PPU_W-1:0];
          default: ;
        endcase
      end
      // results first, so a rate from an earlier request is never masked
      if (out_valid && !out_stall) begin
        if (owed_rates.size() == 0) begin
          $display("%0t: unexpected rate, expected none, actual %0d", $time, out_rate_x10);
          fails++;
        end else begin
          want = owed_rates.pop_front();
          if (out_rate_x10 !== want) begin
            $display("%0t: rate_x10 mismatch, expected %0d, actual %0d",
                     $time, want, out_rate_x10);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == wprm_tb_pkg::OP_PULSE) begin
          tally = tally + 1'b1;
        end else begin
          elapsed = in_now_ms - last_calc_ms;
          if (elapsed >= wprm_pkg::TIME_W'(window_reg)) begin
            held_rate    = rate_from_tally(tally, elapsed);
            tally        = '0;
            last_calc_ms = in_now_ms;
          end
          owed_rates.push_back(held_rate);
        end
      end
    end
    fail_count <= fails;
    owed_count <= owed_rates.size();
  end

endmodule

// File: tb/tb_windowed_pulse_rate_meter_core.sv
// top of the windowed pulse rate meter testbench: clock, reset, request
// stimulus, register settings, result stall pattern, watchdog and verdict
// depends on wprm_pkg, wprm_tb_pkg, wprm_rate_checker and the meter core
`timescale 1ns / 1ps
module tb_windowed_pulse_rate_meter_core;
  import wprm_pkg::*;
  import wprm_tb_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;
  localparam int TAIL_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_PULSE;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RATE_W-1:0]     out_rate_x10;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                    fail_total;
  int                    owed;
  int                    quiet_cycles = 0;
  int                    sent = 0;
  int                    burst_left = 0;
  int unsigned           window_now = WINDOW_RST;
  logic [TIME_W-1:0]     clock_ms = '0;
  int                    stall_mode = 0;
  int                    mode_left = 0;
  int                    stall_tick = 0;

  windowed_pulse_rate_meter_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rate_x10 (out_rate_x10),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  wprm_rate_checker rate_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rate_x10 (out_rate_x10),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_total),
    .owed_count   (owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side stalls on a pattern picked at random, picked anew when its countdown runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ((stall_tick % 7) < 3);
      default: out_stall <= ((stall_tick % 53) < 40);
    endcase
    stall_tick <= stall_tick + 1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input meter_op_e op, input logic [TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_pulses(input int count);
    repeat (count) send_item(OP_PULSE, TIME_W'($urandom));
  endtask

  task automatic send_read(input logic [TIME_W-1:0] delta);
    clock_ms = clock_ms + delta;
    send_item(OP_READ, clock_ms);
  endtask

  // every owed rate back, then room for a pulse still in the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [WIN_W-1:0] win, input logic [SCALE_W-1:0] scale,
                              input logic [PPU_W-1:0] ppu);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= {8'($urandom), win};
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_index <= CFG_PPU;
    cfg_wdata <= {8'($urandom), ppu};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    window_now = win;
  endtask

  function automatic logic [TIME_W-1:0] pick_delta(input int unsigned w);
    int unsigned d;
    case ($urandom_range(0, 9))
      0, 1, 2: d = (w == 0) ? 0 : $urandom_range(0, w - 1);
      3:       d = (w == 0) ? 0 : w - 1;
      4:       d = w;
      5, 6, 7: d = w + $urandom_range(0, w / 2 + 5);
      8:       d = $urandom_range(0, 3);
      default: d = $urandom;
    endcase
    return TIME_W'(d);
  endfunction

  initial begin : stimulus
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // defaults: below window, exactly at window, then a read at the largest time stamp
    send_item(OP_READ, '0);
    send_item(OP_PULSE, '0);
    send_item(OP_PULSE, '1);
    send_item(OP_PULSE, TIME_W'($urandom));
    send_item(OP_READ, TIME_W'(499));
    send_item(OP_READ, TIME_W'(500));
    send_item(OP_PULSE, '1);
    send_item(OP_READ, '1);
    clock_ms = '1;

    // saturated quotient across the time wrap
    wait_idle();
    program_regs(16'd1, 24'hffffff, 16'd1);
    send_pulses(4);
    send_read(TIME_W'(1));

    // zero window with zero elapsed time
    wait_idle();
    program_regs(16'd0, SCALE_RST, PPU_RST);
    send_read('0);
    send_pulses(1);
    send_read(TIME_W'(1));

    // zero pulses per unit, then a read below the widest window
    wait_idle();
    program_regs(16'hffff, 24'd1, 16'd0);
    send_pulses(1);
    send_read(TIME_W'(65535));
    send_read(TIME_W'(10));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case ((phase < 6) ? phase : $urandom_range(0, 5))
        0: program_regs(WINDOW_RST, SCALE_RST, PPU_RST);
        1: program_regs(16'd1, 24'hffffff, 16'hffff);
        2: program_regs(16'hffff, 24'd1, 16'd1);
        3: program_regs(16'($urandom_range(1, 2000)), 24'($urandom),
                        16'($urandom_range(1, 65535)));
        4: program_regs(16'($urandom_range(0, 100)), 24'($urandom_range(1, 1000000)),
                        16'($urandom_range(1, 200)));
        default: program_regs(16'($urandom_range(0, 3)), 24'($urandom_range(1, 1000000)),
                              16'($urandom_range(0, 2)));
      endcase
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 6) != 0) begin
          send_pulses($urandom_range(0, 12));
          send_read(pick_delta(window_now));
        end else if ($urandom_range(0, 1) == 0) begin
          // time jumps anywhere, backwards too
          clock_ms = TIME_W'($urandom);
          send_item(OP_READ, clock_ms);
        end else begin
          send_pulses($urandom_range(1, 3));
        end
      end
    end

    wait_idle();
    if (fail_total == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: windowed_pulse_rate_meter_core.f
+incdir+sv
sv/wprm_pkg.sv
sv/wprm_alu.sv
sv/windowed_pulse_rate_meter_core.sv
tb/wprm_tb_pkg.sv
tb/wprm_rate_checker.sv
tb/tb_windowed_pulse_rate_meter_core.sv
